/* rtl/vrap_pkg.sv */
`timescale 1ns / 1ps

package vrap_pkg;

  // bus access codes
  typedef enum logic [2:0] {
    OP_ADDR_LO = 3'd0,
    OP_ADDR_HI = 3'd1,
    OP_WR_LO   = 3'd2,
    OP_WR_HI   = 3'd3,
    OP_RD_LO   = 3'd4,
    OP_RD_HI   = 3'd5
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_STEP_SELECT = 2'd0,
    CFG_REMAP_MODE  = 2'd1,
    CFG_INC_ON_HIGH = 2'd2
  } cfg_index_t;

  // address remap modes
  typedef enum logic [1:0] {
    REMAP_NONE  = 2'd0,
    REMAP_ROT8  = 2'd1,
    REMAP_ROT9  = 2'd2,
    REMAP_ROT10 = 2'd3
  } remap_t;

  // address step select codes
  localparam logic [1:0] STEP_SEL_1  = 2'd0;
  localparam logic [1:0] STEP_SEL_32 = 2'd1;

  localparam logic [15:0] STEP_1   = 16'd1;
  localparam logic [15:0] STEP_32  = 16'd32;
  localparam logic [15:0] STEP_128 = 16'd128;

  typedef logic [15:0] vaddr_t;
  typedef logic [15:0] vword_t;

endpackage

/* rtl/vrap_ram.sv */
`timescale 1ns / 1ps

module vrap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read-first on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* rtl/video_ram_access_port_core.sv */
`timescale 1ns / 1ps
// Flow: a word is registered in the input register at acceptance and handled there; its
//   read_data word is then captured in the output register once that register can take it.
// Throughput: one word per cycle unless stalled; the input register and the output
//   register form a two-deep pipeline, so back-pressure only stalls when both are full.
// Reset: synchronous, active high; clears address, prefetch buffer, config and valids.
//   Video memory is not cleared (undefined until written), so there is no clearing pass.
module video_ram_access_port_core
  import vrap_pkg::*;
#(
  parameter int MEMORY_WORDS = 32768
) (
  input  logic       clk,
  input  logic       rst,
  // bus access words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] operation,
  input  logic [7:0] data,
  // read results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  localparam int IW = $clog2(MEMORY_WORDS);
  // number of conditional subtracts to fold a 16-bit address into the memory size
  localparam int QB = $clog2((65536 + MEMORY_WORDS - 1) / MEMORY_WORDS);

  // ---------------------------------------------------------------------------
  // Address remap: pass through, or rotate the low 8, 9 or 10 bits left by three.
  // ---------------------------------------------------------------------------
  function automatic vaddr_t remap_addr(input vaddr_t a, input remap_t mode);
    vaddr_t r;
    unique case (mode)
      REMAP_ROT8:  r = {a[15:8],  a[4:0], a[7:5]};
      REMAP_ROT9:  r = {a[15:9],  a[5:0], a[8:6]};
      REMAP_ROT10: r = {a[15:10], a[6:0], a[9:7]};
      default:     r = a;
    endcase
    return r;
  endfunction

  // Fold into the memory size by restoring subtraction.
  function automatic logic [IW-1:0] wrap_index(input vaddr_t r);
    logic [17:0] rem;
    rem = {2'b00, r};
    for (int k = QB - 1; k >= 0; k--) begin
      if (rem >= (18'(MEMORY_WORDS) << k)) begin
        rem = rem - (18'(MEMORY_WORDS) << k);
      end
    end
    return rem[IW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers (always ready; written only while idle by user; unchecked)
  // ---------------------------------------------------------------------------
  logic [1:0] step_select;
  remap_t     remap_mode;
  logic       inc_on_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_select <= 2'd0;
      remap_mode  <= REMAP_NONE;
      inc_on_high <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_SELECT: step_select <= cfg_data;
        CFG_REMAP_MODE:  remap_mode  <= remap_t'(cfg_data);
        CFG_INC_ON_HIGH: inc_on_high <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_data;
  logic       s1_go;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op_t'(operation);
      s1_data <= data;
    end
  end

  // ---------------------------------------------------------------------------
  // Memory: two byte planes, so a byte write needs no read-modify-write.
  // ---------------------------------------------------------------------------
  vaddr_t          word_address;
  vaddr_t          word_address_next;
  logic [IW-1:0]   mem_index;
  logic            we_lo;
  logic            we_hi;
  logic [7:0]      q_lo;
  logic [7:0]      q_hi;

  assign mem_index = wrap_index(remap_addr(word_address, remap_mode));
  assign we_lo     = s1_go && (s1_op == OP_WR_LO);
  assign we_hi     = s1_go && (s1_op == OP_WR_HI);

  vrap_ram #(.WIDTH(8), .DEPTH(MEMORY_WORDS)) u_ram_lo (
    .clk   (clk),
    .we    (we_lo),
    .waddr (mem_index),
    .wdata (s1_data),
    .raddr (mem_index),
    .rdata (q_lo)
  );

  vrap_ram #(.WIDTH(8), .DEPTH(MEMORY_WORDS)) u_ram_hi (
    .clk   (clk),
    .we    (we_hi),
    .waddr (mem_index),
    .wdata (s1_data),
    .raddr (mem_index),
    .rdata (q_hi)
  );

  // ---------------------------------------------------------------------------
  // Prefetch buffer. A load issues the RAM read in the access cycle; the word
  // arrives in the following cycle and is used directly (pf_pending) and captured.
  // The RAM reads old data on a same-address write, so the written byte is
  // forwarded over it.
  // ---------------------------------------------------------------------------
  vword_t     prefetch_word;
  logic       pf_pending;
  logic       fwd_lo;
  logic       fwd_hi;
  logic [7:0] fwd_byte;
  vword_t     pf_loaded;
  vword_t     pf_cur;
  logic       advance;
  logic       load;
  vaddr_t     step;
  logic [7:0] result;

  assign pf_loaded = {fwd_hi ? fwd_byte : q_hi, fwd_lo ? fwd_byte : q_lo};
  assign pf_cur    = pf_pending ? pf_loaded : prefetch_word;

  // data access on the byte selected by inc_on_high triggers load + advance
  always_comb begin
    unique case (s1_op)
      OP_WR_LO, OP_RD_LO: advance = !inc_on_high;
      OP_WR_HI, OP_RD_HI: advance = inc_on_high;
      default:            advance = 1'b0;
    endcase
  end

  assign load = s1_go && advance;

  always_comb begin
    priority case (step_select)
      STEP_SEL_1:  step = STEP_1;
      STEP_SEL_32: step = STEP_32;
      default:     step = STEP_128;
    endcase
  end

  always_comb begin
    word_address_next = word_address;
    result            = 8'd0;
    unique case (s1_op)
      OP_ADDR_LO: word_address_next = {word_address[15:8], s1_data};
      OP_ADDR_HI: word_address_next = {s1_data, word_address[7:0]};
      OP_RD_LO:   result = pf_cur[7:0];
      OP_RD_HI:   result = pf_cur[15:8];
      default: ;
    endcase
    if (advance) begin
      word_address_next = word_address + step;  // wraps at 16 bits
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_address  <= '0;
      prefetch_word <= '0;
      pf_pending    <= 1'b0;
      fwd_lo        <= 1'b0;
      fwd_hi        <= 1'b0;
    end else begin
      if (pf_pending) begin
        prefetch_word <= pf_loaded;
      end
      pf_pending <= load;
      fwd_lo     <= load && we_lo;
      fwd_hi     <= load && we_hi;
      if (s1_go) begin
        word_address <= word_address_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fwd_byte <= s1_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      read_data <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pending_from_load : assert property (@(posedge clk) disable iff (rst)
    pf_pending |-> $past(load))
    else $error("prefetch pending without a load");

  a_one_plane_write : assert property (@(posedge clk) disable iff (rst)
    !(we_lo && we_hi))
    else $error("both byte planes written at once");

  a_addr_holds : assert property (@(posedge clk) disable iff (rst)
    (!rst && !s1_go) |=> $stable(word_address))
    else $error("word address moved without an access");

  a_nonread_zero : assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_op != OP_RD_LO && s1_op != OP_RD_HI) |=> (read_data == 8'd0))
    else $error("non-read access returned nonzero data");

endmodule
